@@ hw/rtl/vspd_pkg.sv @@
// Shared constants, types and status codes for the video SPI packet decoder.
package vspd_pkg;

   // Packet geometry
   localparam int unsigned PACKET_BYTES      = 164;
   localparam int unsigned PIXELS_PER_PACKET = 80;
   localparam int unsigned HEADER_BYTES      = 4;

   // CRC-16 generator and header masks
   localparam logic [15:0] CRC_POLY       = 16'h1021;
   localparam logic [7:0]  DISCARD_NIBBLE = 8'h0f;
   localparam logic [7:0]  ID_LOW_MASK    = 8'h0f;

   // Header byte positions and the position of the first pixel's second byte
   localparam logic [7:0] POS_ID        = 8'd0;
   localparam logic [7:0] POS_FRAME     = 8'd1;
   localparam logic [7:0] POS_CRC_HIGH  = 8'd2;
   localparam logic [7:0] POS_CRC_LOW   = 8'd3;
   localparam logic [7:0] POS_FIRST_PIX = 8'd5;

   typedef enum logic [1:0] {
      STATUS_VALID    = 2'd0,
      STATUS_CRC_FAIL = 2'd1,
      STATUS_DISCARD  = 2'd2
   } status_type;

   // One input byte as held in the input stage
   typedef struct packed {
      logic [7:0] data_byte;
      logic       packet_start;
   } req_item_type;

   // One decoded pixel
   typedef struct packed {
      logic [15:0] pixel_value;
      logic [6:0]  pixel_index;
      logic [7:0]  frame_number;
      status_type  frame_status;
      logic        last_pixel;
   } rsp_item_type;

   // Pipeline control between the stages
   typedef struct packed {
      logic item_valid;
      logic advance;
   } stage_ctrl_type;

endpackage

@@ hw/rtl/vspd_if.sv @@
// Valid/ready channel interfaces for the byte input and the pixel output.
interface vspd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       packet_start;

   modport source (output valid, output data_byte, output packet_start, input ready);
   modport sink (input valid, input data_byte, input packet_start, output ready);
endinterface

interface vspd_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] pixel_value;
   logic [6:0]  pixel_index;
   logic [7:0]  frame_number;
   logic [1:0]  frame_status;
   logic        last_pixel;

   modport source (output valid, output pixel_value, output pixel_index,
                   output frame_number, output frame_status, output last_pixel,
                   input ready);
   modport sink (input valid, input pixel_value, input pixel_index,
                 input frame_number, input frame_status, input last_pixel,
                 output ready);
endinterface

@@ hw/rtl/vspd_in_stage.sv @@
// Input register stage: captures one byte per transfer.
module vspd_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  vspd_pkg::req_item_type req_item,
   input  logic                  advance,
   output vspd_pkg::stage_ctrl_type ctrl,
   output vspd_pkg::req_item_type item
);
   import vspd_pkg::*;

   logic         valid_ff, valid_in;
   req_item_type item_ff;
   logic         xfer;

   // Stage frees up when empty or when its item moves on
   assign req_ready = !valid_ff || advance;
   assign xfer      = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      if (xfer) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset
   always_ff @(posedge clock) begin
      if (xfer) begin
         item_ff <= req_item;
      end
   end

   assign ctrl.item_valid = valid_ff;
   assign ctrl.advance    = advance;
   assign item            = item_ff;
endmodule

@@ hw/rtl/vspd_core.sv @@
// Packet decode: byte position, header capture, CRC-16 and pixel assembly.
module vspd_core (
   input  logic                     clock,
   input  logic                     reset,
   input  vspd_pkg::stage_ctrl_type ctrl,
   input  vspd_pkg::req_item_type   item,
   output logic                     produce,
   output vspd_pkg::rsp_item_type   result
);
   import vspd_pkg::*;

   // One byte of CRC-16, MSB first
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

   logic [7:0]  byte_count_ff, byte_count_in;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] rx_crc_ff, rx_crc_in;
   logic        discard_ff, discard_in;
   logic [7:0]  number_ff, number_in;
   logic [7:0]  high_byte_ff, high_byte_in;

   logic        fire;
   logic        in_packet;
   logic [7:0]  pos;
   logic [7:0]  pos_from_first;
   logic [6:0]  idx;
   logic [7:0]  crc_byte;
   logic [15:0] crc_base;
   logic [15:0] crc_next;

   assign fire = ctrl.item_valid && ctrl.advance;

   // Byte position within the packet
   assign pos            = item.packet_start ? 8'd0 : byte_count_ff;
   assign in_packet      = pos < 8'(PACKET_BYTES);
   assign pos_from_first = pos - POS_FIRST_PIX;
   assign idx            = pos_from_first[7:1];

   // CRC input: ID top nibble and both CRC bytes count as zero
   always_comb begin
      crc_base = crc_ff;
      crc_byte = item.data_byte;
      if (pos == POS_ID) begin
         crc_base = 16'h0000;
         crc_byte = item.data_byte & ID_LOW_MASK;
      end else if (pos == POS_CRC_HIGH || pos == POS_CRC_LOW) begin
         crc_byte = 8'h00;
      end
   end

   assign crc_next = crc_feed(crc_base, crc_byte);

   // State update for an accepted byte
   always_comb begin
      byte_count_in = byte_count_ff;
      crc_in        = crc_ff;
      rx_crc_in     = rx_crc_ff;
      discard_in    = discard_ff;
      number_in     = number_ff;
      high_byte_in  = high_byte_ff;
      if (fire && in_packet) begin
         byte_count_in = pos + 8'd1;
         crc_in        = crc_next;
         if (pos == POS_ID) begin
            discard_in = (item.data_byte & DISCARD_NIBBLE) == DISCARD_NIBBLE;
         end
         if (pos == POS_FRAME && !discard_ff) begin
            number_in = item.data_byte;
         end
         if (pos == POS_CRC_HIGH && !discard_ff) begin
            rx_crc_in[15:8] = item.data_byte;
         end
         if (pos == POS_CRC_LOW && !discard_ff) begin
            rx_crc_in[7:0] = item.data_byte;
         end
         if (pos >= 8'(HEADER_BYTES) && !pos[0]) begin
            high_byte_in = item.data_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= 8'd0;
         crc_ff        <= 16'h0000;
         rx_crc_ff     <= 16'h0000;
         discard_ff    <= 1'b0;
         number_ff     <= 8'd0;
         high_byte_ff  <= 8'd0;
      end else begin
         byte_count_ff <= byte_count_in;
         crc_ff        <= crc_in;
         rx_crc_ff     <= rx_crc_in;
         discard_ff    <= discard_in;
         number_ff     <= number_in;
         high_byte_ff  <= high_byte_in;
      end
   end

   // Pixel result on the second byte of each pair
   assign produce = fire && in_packet && pos >= POS_FIRST_PIX && pos[0]
                    && idx < 7'(PIXELS_PER_PACKET);

   always_comb begin
      result.pixel_index  = idx;
      result.frame_number = number_ff;
      result.last_pixel   = idx == 7'(PIXELS_PER_PACKET - 1);
      if (discard_ff) begin
         result.pixel_value  = 16'h0000;
         result.frame_status = STATUS_DISCARD;
      end else begin
         result.pixel_value  = {high_byte_ff, item.data_byte};
         result.frame_status = (crc_next != rx_crc_ff) ? STATUS_CRC_FAIL : STATUS_VALID;
      end
   end
endmodule

@@ hw/rtl/vspd_out_reg.sv @@
// Output register: holds one pixel until the downstream transfer.
module vspd_out_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   produce,
   input  vspd_pkg::rsp_item_type result,
   output logic                   advance,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output vspd_pkg::rsp_item_type rsp_item
);
   import vspd_pkg::*;

   logic         valid_ff, valid_in;
   rsp_item_type item_ff;
   logic         load;

   // Pipeline moves when the register is empty or being drained
   assign advance = !valid_ff || rsp_ready;
   assign load    = produce && advance;

   always_comb begin
      valid_in = valid_ff && !rsp_ready;
      if (load) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;
endmodule

@@ hw/rtl/video_spi_packet_decoder.sv @@
// Top level of the video SPI packet decoder.
// Path: a pixel's second data byte is captured in the input register on its transfer,
// and the pixel is loaded into the output register when that byte moves on.
// Throughput: one byte per cycle unless the output stalls; the byte CRC update and decode
// sit between the input register and the output register.
// Reset (synchronous) empties both stages and clears the byte count, CRC,
// received CRC, discard flag, frame number and held high byte.
module video_spi_packet_decoder (
   input logic         clock,
   input logic         reset,
   vspd_req_if.sink    req_if,
   vspd_rsp_if.source  rsp_if
);
   import vspd_pkg::*;

   req_item_type   req_item;
   req_item_type   item;
   stage_ctrl_type ctrl;
   rsp_item_type   result;
   rsp_item_type   rsp_item;
   logic           advance;
   logic           produce;
   logic           req_ready;
   logic           rsp_valid;

   assign req_item.data_byte    = req_if.data_byte;
   assign req_item.packet_start = req_if.packet_start;
   assign req_if.ready          = req_ready;

   vspd_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .advance   (advance),
      .ctrl      (ctrl),
      .item      (item)
   );

   vspd_core u_core (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (ctrl),
      .item    (item),
      .produce (produce),
      .result  (result)
   );

   vspd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .produce   (produce),
      .result    (result),
      .advance   (advance),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_if.ready),
      .rsp_item  (rsp_item)
   );

   assign rsp_if.valid        = rsp_valid;
   assign rsp_if.pixel_value  = rsp_item.pixel_value;
   assign rsp_if.pixel_index  = rsp_item.pixel_index;
   assign rsp_if.frame_number = rsp_item.frame_number;
   assign rsp_if.frame_status = rsp_item.frame_status;
   assign rsp_if.last_pixel   = rsp_item.last_pixel;
endmodule

@@ hw/rtl/vspd_checker.sv @@
// Port-level checks on the decoder output, bound to the top level.
module vspd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] pixel_value,
   input logic [6:0]  pixel_index,
   input logic [1:0]  frame_status,
   input logic        last_pixel
);
   import vspd_pkg::*;

   // Last pixel flag sits exactly on the final index
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (last_pixel == (pixel_index == 7'(PIXELS_PER_PACKET - 1))))
      else $error("last_pixel does not match pixel_index");

   // Discard packets carry zero pixels
   a_discard_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && frame_status == STATUS_DISCARD) |-> pixel_value == 16'h0000)
      else $error("discard pixel not zero");

   // Index stays inside the packet
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pixel_index < 7'(PIXELS_PER_PACKET))
      else $error("pixel_index out of range");

   // Nothing is offered right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled pixel stays valid and keeps its value and index
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(pixel_value)
                                     && $stable(pixel_index)))
      else $error("stalled result changed");
endmodule

bind video_spi_packet_decoder vspd_checker u_vspd_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .pixel_value  (rsp_if.pixel_value),
   .pixel_index  (rsp_if.pixel_index),
   .frame_status (rsp_if.frame_status),
   .last_pixel   (rsp_if.last_pixel)
);
